@@ rtl/core/rcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay channel timer controller package
// Shared transaction types, register map, mode codes and reset values.
// ----------------------------------------------------------------------------
package rcc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOMENTARY_MS    = 2'd0,
		CFG_LIGHT_ON_MS     = 2'd1,
		CFG_LATCH_HOLDOFF_MS = 2'd2,
		CFG_PUSHING_MS      = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LATCH     = 2'd0,
		MODE_PUSHING   = 2'd1,
		MODE_MOMENTARY = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	localparam logic [3:0] BTN_ONE   = 4'h1;
	localparam logic [3:0] BTN_TWO   = 4'h2;
	localparam logic [3:0] BTN_THREE = 4'h4;
	localparam logic [3:0] BTN_FOUR  = 4'h8;

	localparam logic [17:0] MOMENTARY_MS_RST     = 18'd7000;
	localparam logic [17:0] LIGHT_ON_MS_RST      = 18'd3000;
	localparam logic [15:0] LATCH_HOLDOFF_MS_RST = 16'd1000;
	localparam logic [15:0] PUSHING_MS_RST       = 16'd1000;

	typedef struct packed {
		logic [17:0] momentary_ms;
		logic [17:0] light_on_ms;
		logic [15:0] latch_holdoff_ms;
		logic [15:0] pushing_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        func;
		logic [3:0]  button_bits;
		logic        known_remote;
		logic [7:0]  mode_byte;
	} pass_item_t;

	typedef struct packed {
		logic [2:0] relay_toggle;
		logic       lamp_on;
	} result_item_t;

endpackage
`default_nettype wire

@@ rtl/core/rcc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay channel timer controller channel interfaces
// Valid/ready channels for loop pass transactions and result transactions.
// ----------------------------------------------------------------------------
interface rcc_pass_if import rcc_pkg::*; ();
	logic       valid;
	logic       ready;
	pass_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcc_result_if import rcc_pkg::*; ();
	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/relay_channel_timer_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay channel timer controller
// Relay toggle and lamp controller driven by remote events and time.
//
// Each transaction on the pass channel is one control loop pass: the current
// millisecond time and an optional remote event. Each pass yields exactly one
// transaction on the result channel: the relay to invert (0 for none) and
// the lamp level after the pass. Timing settings are written through the
// configuration port; the user must write them only while no pass is in
// flight, as the block itself does not enforce this. A pass is captured in
// an input register and resolved by the engine into the result register
// once that register is free or being taken. While the receiver does not
// stall, one pass is accepted per cycle. When the receiver stalls, the
// result register holds and the input register can still take one more
// pass; after that the pass channel drops ready.
// Reset clears all deadlines, the lamp and the pipeline, and loads the
// default timing settings.
// ----------------------------------------------------------------------------
module relay_channel_timer_controller import rcc_pkg::*; #(
	parameter int CHANNELS  = 4,
	parameter int TIME_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	rcc_pass_if.sink                   pass,
	rcc_result_if.source               result
);

	cfg_t         cfg;
	pass_item_t   pass_s1;
	logic         valid_s1;
	result_item_t res_d;
	result_item_t res_q;
	logic         res_valid_q;
	logic         step;

	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign pass.ready = !valid_s1 || step;

	rcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rcc_engine #(
		.CHANNELS  (CHANNELS),
		.TIME_BITS (TIME_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (pass_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pass.ready) begin
				valid_s1 <= pass.valid;
			end
			if (step) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pass.valid && pass.ready) begin
			pass_s1 <= pass.data;
		end
		if (step) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire

@@ rtl/core/rcc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay channel timer controller configuration registers
// Write-only register file holding the timing settings.
// ----------------------------------------------------------------------------
module rcc_cfg_regs import rcc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.momentary_ms     <= MOMENTARY_MS_RST;
			cfg_q.light_on_ms      <= LIGHT_ON_MS_RST;
			cfg_q.latch_holdoff_ms <= LATCH_HOLDOFF_MS_RST;
			cfg_q.pushing_ms       <= PUSHING_MS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_MOMENTARY_MS:     cfg_q.momentary_ms     <= cfg_wdata;
				CFG_LIGHT_ON_MS:      cfg_q.light_on_ms      <= cfg_wdata;
				CFG_LATCH_HOLDOFF_MS: cfg_q.latch_holdoff_ms <= cfg_wdata[15:0];
				CFG_PUSHING_MS:       cfg_q.pushing_ms       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/rcc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay channel timer controller engine
// Channel state, event handling, lamp timer and expiry pick for one pass.
// ----------------------------------------------------------------------------
module rcc_engine import rcc_pkg::*; #(
	parameter int CHANNELS  = 4,
	parameter int TIME_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  pass_item_t item,
	input  cfg_t       cfg,
	output result_item_t res
);

	localparam int EW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [TIME_BITS-1:0] rev_q [CHANNELS];
	logic [TIME_BITS-1:0] latch_q;
	logic [2:0]           last_btn_q;
	logic [TIME_BITS-1:0] lamp_dl_q;
	logic                 lamp_q;

	logic [TIME_BITS-1:0] rev_n [CHANNELS];
	logic [TIME_BITS-1:0] latch_n;
	logic [2:0]           last_btn_n;
	logic [TIME_BITS-1:0] lamp_dl_n;
	logic                 lamp_n;
	logic [2:0]           toggle;

	logic [EW-1:0]        now_e, mom_e, push_e, hold_e, light_e;
	logic [TIME_BITS-1:0] now_v, mom_sum, push_sum, hold_sum, light_sum;
	logic                 ev;

	assign now_e     = EW'(item.now_ms);
	assign mom_e     = now_e + EW'(cfg.momentary_ms);
	assign push_e    = now_e + EW'(cfg.pushing_ms);
	assign hold_e    = now_e + EW'(cfg.latch_holdoff_ms);
	assign light_e   = now_e + EW'(cfg.light_on_ms);
	assign now_v     = now_e[TIME_BITS-1:0];
	assign mom_sum   = mom_e[TIME_BITS-1:0];
	assign push_sum  = push_e[TIME_BITS-1:0];
	assign hold_sum  = hold_e[TIME_BITS-1:0];
	assign light_sum = light_e[TIME_BITS-1:0];
	assign ev        = item.func & item.known_remote;

	always_comb begin
		logic [2:0]           btn;
		logic [1:0]           bidx;
		mode_t                mode;
		logic [TIME_BITS-1:0] latch_d;
		logic                 hit;
		logic                 found;

		case (item.button_bits)
			BTN_ONE:   btn = 3'd1;
			BTN_TWO:   btn = 3'd2;
			BTN_THREE: btn = 3'd3;
			BTN_FOUR:  btn = 3'd4;
			default:   btn = 3'd0;
		endcase
		if (32'(btn) > CHANNELS) begin
			btn = 3'd0;
		end
		bidx    = 2'(btn - 3'd1);
		mode    = mode_t'(item.mode_byte[2*bidx +: 2]);
		latch_d = (btn != last_btn_q) ? '0 : latch_q;

		latch_n    = ev ? latch_d : latch_q;
		last_btn_n = ev ? btn : last_btn_q;
		toggle     = 3'd0;
		found      = 1'b0;

		for (int i = 0; i < CHANNELS; i++) begin
			hit = ev && (btn != 3'd0) && ({1'b0, btn} == 4'(i + 1));
			rev_n[i] = rev_q[i];
			if (hit) begin
				case (mode)
					MODE_LATCH: begin
						if (now_v > latch_d) begin
							toggle = 3'(i + 1);
							found  = 1'b1;
						end
						latch_n  = hold_sum;
						rev_n[i] = '0;
					end
					MODE_MOMENTARY: begin
						if (rev_q[i] == '0) begin
							toggle = 3'(i + 1);
							found  = 1'b1;
						end
						rev_n[i] = mom_sum;
					end
					MODE_PUSHING: begin
						if (rev_q[i] == '0) begin
							toggle = 3'(i + 1);
							found  = 1'b1;
						end
						rev_n[i] = push_sum;
					end
					default: ;
				endcase
			end
		end

		lamp_n    = lamp_q;
		lamp_dl_n = lamp_dl_q;
		if (ev) begin
			lamp_n    = 1'b1;
			lamp_dl_n = light_sum;
		end
		if (lamp_dl_n != '0 && now_v > lamp_dl_n) begin
			lamp_n    = 1'b0;
			lamp_dl_n = '0;
		end

		for (int i = 0; i < CHANNELS; i++) begin
			if (!found && rev_n[i] != '0 && now_v > rev_n[i]) begin
				toggle   = 3'(i + 1);
				rev_n[i] = '0;
				found    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rev_q[i] <= '0;
			end
			latch_q    <= '0;
			last_btn_q <= 3'd0;
			lamp_dl_q  <= '0;
			lamp_q     <= 1'b0;
		end else if (step) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rev_q[i] <= rev_n[i];
			end
			latch_q    <= latch_n;
			last_btn_q <= last_btn_n;
			lamp_dl_q  <= lamp_dl_n;
			lamp_q     <= lamp_n;
		end
	end

	assign res.relay_toggle = toggle;
	assign res.lamp_on      = lamp_n;

	// A relay number never names a channel that does not exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (4'(res.relay_toggle) <= CHANNELS))
		else $error("relay number beyond channel count");

	// An idle lamp never keeps a pending deadline.
	assert property (@(posedge clk) disable iff (!arst_n)
		!lamp_q |-> (lamp_dl_q == '0))
		else $error("lamp off with armed deadline");

	// State moves only when a pass is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(lamp_q) && $stable(last_btn_q) && $stable(latch_q)))
		else $error("state changed without a pass");

endmodule
`default_nettype wire

@@ tb/rcc_relay_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay channel timer controller result checker
// Keeps its own copy of the relay revert deadlines, the latch hold-off, the
// lamp timer and the timing settings. It predicts the result of every
// accepted loop pass and compares each result transaction field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module rcc_relay_checker import rcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  pass_valid,
	input  logic                  pass_ready,
	input  pass_item_t            pass_data,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_item_t          result_data,
	output int                    failures,
	output int                    pending,
	output int                    results_checked,
	output int                    toggles_seen
);
	localparam int RELAYS = 4;

	logic [17:0] momentary_delay;
	logic [17:0] light_delay;
	logic [15:0] holdoff_window;
	logic [15:0] pushing_delay;

	logic [31:0] revert_at [RELAYS];
	logic [31:0] latch_until;
	logic [2:0]  held_button;
	logic [31:0] lamp_until;
	logic        lamp_lit;

	result_item_t predicted_outcomes [$];

	task automatic resolve_loop_pass(input pass_item_t p, output result_item_t r);
		logic [31:0] now;
		logic [2:0]  button;
		logic [2:0]  toggle;
		mode_t       mode;
		int          idx;
		now = p.now_ms;
		toggle = 3'd0;
		if (p.func && p.known_remote) begin
			case (p.button_bits)
				BTN_ONE:   button = 3'd1;
				BTN_TWO:   button = 3'd2;
				BTN_THREE: button = 3'd3;
				BTN_FOUR:  button = 3'd4;
				default:   button = 3'd0;
			endcase
			if (button != held_button)
				latch_until = '0;
			held_button = button;
			if (button != 3'd0) begin
				idx = button - 1;
				mode = mode_t'(p.mode_byte[2*idx +: 2]);
				case (mode)
					MODE_LATCH: begin
						if (now > latch_until)
							toggle = button;
						latch_until = now + 32'(holdoff_window);
						revert_at[idx] = '0;
					end
					MODE_MOMENTARY: begin
						if (revert_at[idx] == '0)
							toggle = button;
						revert_at[idx] = now + 32'(momentary_delay);
					end
					MODE_PUSHING: begin
						if (revert_at[idx] == '0)
							toggle = button;
						revert_at[idx] = now + 32'(pushing_delay);
					end
					default: ;
				endcase
			end
			lamp_lit = 1'b1;
			lamp_until = now + 32'(light_delay);
		end
		if (lamp_until != '0 && now > lamp_until) begin
			lamp_lit = 1'b0;
			lamp_until = '0;
		end
		for (int i = 0; i < RELAYS; i++) begin
			if (toggle == 3'd0 && revert_at[i] != '0 && now > revert_at[i]) begin
				toggle = 3'(i + 1);
				revert_at[i] = '0;
			end
		end
		r.relay_toggle = toggle;
		r.lamp_on = lamp_lit;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_item_t want;
		if (!arst_n) begin
			momentary_delay = MOMENTARY_MS_RST;
			light_delay = LIGHT_ON_MS_RST;
			holdoff_window = LATCH_HOLDOFF_MS_RST;
			pushing_delay = PUSHING_MS_RST;
			for (int i = 0; i < RELAYS; i++)
				revert_at[i] = '0;
			latch_until = '0;
			held_button = 3'd0;
			lamp_until = '0;
			lamp_lit = 1'b0;
			predicted_outcomes.delete();
			failures = 0;
			pending = 0;
			results_checked = 0;
			toggles_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					CFG_MOMENTARY_MS:     momentary_delay = cfg_wdata;
					CFG_LIGHT_ON_MS:      light_delay = cfg_wdata;
					CFG_LATCH_HOLDOFF_MS: holdoff_window = cfg_wdata[15:0];
					CFG_PUSHING_MS:       pushing_delay = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (pass_valid && pass_ready) begin
				resolve_loop_pass(pass_data, want);
				predicted_outcomes.push_back(want);
			end
			if (result_valid && result_ready) begin
				results_checked++;
				if (result_data.relay_toggle != 3'd0)
					toggles_seen++;
				if (predicted_outcomes.size() == 0) begin
					failures++;
					$display("%0t ns: unexpected result transaction: expected none, actual %0d/%0d",
						$time, result_data.relay_toggle, result_data.lamp_on);
				end else begin
					want = predicted_outcomes.pop_front();
					if (result_data.relay_toggle !== want.relay_toggle) begin
						failures++;
						$display("%0t ns: relay_toggle mismatch: expected %0d, actual %0d",
							$time, want.relay_toggle, result_data.relay_toggle);
					end
					if (result_data.lamp_on !== want.lamp_on) begin
						failures++;
						$display("%0t ns: lamp_on mismatch: expected %0d, actual %0d",
							$time, want.lamp_on, result_data.lamp_on);
					end
				end
			end
			pending = predicted_outcomes.size();
		end
	end
endmodule

@@ tb/tb_relay_channel_timer_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay channel timer controller testbench
// Drives loop pass transactions, first a directed sequence through latch,
// pushing, momentary and ignored events, deadline expiry and time wrap, then
// random passes under seven timing settings with sender gaps and receiver
// stalls. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_relay_channel_timer_controller;
	import rcc_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int PHASES           = 7;
	localparam int PASSES_PER_PHASE = 220;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int          failures;
	int          pending;
	int          results_checked;
	int          toggles_seen;
	int          cycle_count = 0;
	int          passes_sent = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	logic [31:0] clock_ms = '0;

	rcc_pass_if   loop_pass ();
	rcc_result_if loop_result ();

	relay_channel_timer_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pass      (loop_pass),
		.result    (loop_result)
	);

	rcc_relay_checker outcome_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.pass_valid      (loop_pass.valid),
		.pass_ready      (loop_pass.ready),
		.pass_data       (loop_pass.data),
		.result_valid    (loop_result.valid),
		.result_ready    (loop_result.ready),
		.result_data     (loop_result.data),
		.failures        (failures),
		.pending         (pending),
		.results_checked (results_checked),
		.toggles_seen    (toggles_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[relay_channel_timer_controller] ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		loop_result.ready <= ($urandom_range(0, 99) >= stall_pct);

	task automatic offer_pass(input logic [31:0] now, input logic func, input logic [3:0] bits,
		input logic known, input logic [7:0] modes);
		loop_pass.valid <= 1'b1;
		loop_pass.data <= '{now_ms: now, func: func, button_bits: bits,
			known_remote: known, mode_byte: modes};
		@(posedge clk);
		while (!loop_pass.ready)
			@(posedge clk);
		passes_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results;
		loop_pass.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_timing(input logic [17:0] momentary, input logic [17:0] light,
		input logic [17:0] holdoff, input logic [17:0] pushing);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_MOMENTARY_MS;
		cfg_wdata <= momentary;
		@(negedge clk);
		cfg_idx <= CFG_LIGHT_ON_MS;
		cfg_wdata <= light;
		@(negedge clk);
		cfg_idx <= CFG_LATCH_HOLDOFF_MS;
		cfg_wdata <= holdoff;
		@(negedge clk);
		cfg_idx <= CFG_PUSHING_MS;
		cfg_wdata <= pushing;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int          kind;
		int          pick;
		logic        func_bit;
		logic        known_bit;
		logic [3:0]  bits;
		logic [7:0]  modes;
		logic [7:0]  all_latch;
		all_latch = {MODE_LATCH, MODE_LATCH, MODE_LATCH, MODE_LATCH};
		loop_pass.valid = 1'b0;
		loop_pass.data = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MOMENTARY_MS;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_pass(32'd0, 1'b0, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd10, 1'b1, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd20, 1'b1, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd1500, 1'b1, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd1600, 1'b1, BTN_TWO, 1'b1,
			{MODE_LATCH, MODE_LATCH, MODE_MOMENTARY, MODE_LATCH});
		offer_pass(32'd1700, 1'b1, BTN_TWO, 1'b1,
			{MODE_LATCH, MODE_LATCH, MODE_MOMENTARY, MODE_LATCH});
		offer_pass(32'd1800, 1'b1, BTN_THREE, 1'b1,
			{MODE_LATCH, MODE_PUSHING, MODE_LATCH, MODE_LATCH});
		offer_pass(32'd1900, 1'b1, BTN_FOUR, 1'b1,
			{MODE_NONE, MODE_LATCH, MODE_LATCH, MODE_LATCH});
		offer_pass(32'd1950, 1'b1, BTN_ONE, 1'b0, all_latch);
		offer_pass(32'd2000, 1'b1, 4'b0000, 1'b1, all_latch);
		offer_pass(32'd2100, 1'b1, 4'b0011, 1'b1, all_latch);
		offer_pass(32'd2200, 1'b1, 4'b1111, 1'b1, all_latch);
		offer_pass(32'd3000, 1'b0, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd9000, 1'b0, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd9100, 1'b1, BTN_THREE, 1'b1,
			{MODE_LATCH, MODE_PUSHING, MODE_LATCH, MODE_LATCH});
		offer_pass(32'd9200, 1'b1, BTN_FOUR, 1'b1,
			{MODE_MOMENTARY, MODE_LATCH, MODE_LATCH, MODE_LATCH});
		offer_pass(32'd20000, 1'b1, BTN_ONE, 1'b1, all_latch);
		offer_pass(32'd20001, 1'b0, BTN_ONE, 1'b0, all_latch);
		offer_pass(32'd20002, 1'b0, BTN_ONE, 1'b0, all_latch);
		offer_pass(32'hFFFF_FC18, 1'b1, BTN_FOUR, 1'b1,
			{MODE_PUSHING, MODE_LATCH, MODE_LATCH, MODE_LATCH});
		offer_pass(32'hFFFF_FFFF, 1'b0, BTN_FOUR, 1'b1, all_latch);
		offer_pass(32'hFFFF_FFFF, 1'b1, BTN_FOUR, 1'b1,
			{MODE_PUSHING, MODE_LATCH, MODE_LATCH, MODE_LATCH});
		offer_pass(32'hFFFF_F448, 1'b1, BTN_TWO, 1'b1,
			{MODE_NONE, MODE_NONE, MODE_NONE, MODE_NONE});
		offer_pass(32'd5, 1'b0, 4'b1111, 1'b1, 8'hFF);
		offer_pass(32'hFFFF_FFFF, 1'b1, 4'b1111, 1'b1, 8'hFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				1: load_timing(18'd1000, 18'd1000, 18'd0, 18'd0);
				2: load_timing(18'd255000, 18'd255000, 18'd65535, 18'd65535);
				3: load_timing(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
				4: load_timing(18'd0, 18'd0, 18'h30000, 18'h20001);
				5: load_timing(18'($urandom_range(1000, 255000)),
					18'($urandom_range(1000, 255000)),
					18'($urandom_range(0, 65535)), 18'($urandom_range(0, 65535)));
				6: load_timing(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
				default: ;
			endcase
			case (phase % 4)
				1: begin
					gap_pct = 54;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 54;
				end
				3: begin
					gap_pct = 20;
					stall_pct = 20;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int n = 0; n < PASSES_PER_PHASE; n++) begin
				if (n == PASSES_PER_PHASE / 2)
					drain_results();
				kind = $urandom_range(0, 99);
				pick = $urandom_range(0, 99);
				if (kind < 93) begin
					if (pick < 40)
						clock_ms = clock_ms + $urandom_range(0, 30);
					else if (pick < 85)
						clock_ms = clock_ms + $urandom_range(0, 3000);
					else
						clock_ms = clock_ms + $urandom_range(0, 300000);
				end else if (kind < 97) begin
					clock_ms = $urandom;
				end else begin
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300000);
				end
				func_bit = 1'b0;
				known_bit = 1'($urandom_range(0, 1));
				bits = 4'($urandom);
				modes = 8'($urandom);
				if (kind < 55 || kind >= 93) begin
					func_bit = 1'b1;
					known_bit = 1'b1;
					bits = BTN_ONE << $urandom_range(0, 3);
				end else if (kind >= 80) begin
					func_bit = 1'($urandom_range(0, 1));
				end
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
					loop_pass.valid <= 1'b0;
					repeat ($urandom_range(1, 4)) @(negedge clk);
				end
				offer_pass(clock_ms, func_bit, bits, known_bit, modes);
			end
		end
		drain_results();

		$display("Run covered %0d loop passes under %0d timing settings with mixed idling.",
			passes_sent, PHASES);
		$display("Checked %0d results, %0d of them relay toggles, with %0d mismatches.",
			results_checked, toggles_seen, failures);
		if (failures == 0 && pending == 0)
			$display("[relay_channel_timer_controller] OK");
		else
			$display("[relay_channel_timer_controller] ERROR");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/rcc_pkg.sv
rtl/core/rcc_if.sv
rtl/core/rcc_cfg_regs.sv
rtl/core/rcc_engine.sv
rtl/core/relay_channel_timer_controller.sv
tb/rcc_relay_checker.sv
tb/tb_relay_channel_timer_controller.sv
